// File: src/v3alu_pkg.sv
// shared codes, types and helpers of the vec3 fixed-point alu
package v3alu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [3:0] KIND_ADD   = 4'd0;
    localparam logic [3:0] KIND_SUB   = 4'd1;
    localparam logic [3:0] KIND_SCALE = 4'd2;
    localparam logic [3:0] KIND_DIV   = 4'd3;
    localparam logic [3:0] KIND_NEG   = 4'd4;
    localparam logic [3:0] KIND_DOT   = 4'd5;
    localparam logic [3:0] KIND_CROSS = 4'd6;
    localparam logic [3:0] KIND_LENSQ = 4'd7;
    localparam logic [3:0] KIND_LEN   = 4'd8;
    localparam logic [3:0] KIND_DIST  = 4'd9;
    localparam logic [3:0] KIND_NORM  = 4'd10;
    localparam logic [3:0] KIND_LERP  = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    // result fields carried down the pipeline
    typedef struct packed {
        logic [3:0]       kind;
        logic             far;
        logic [2:0][31:0] r;
        logic [31:0]      rs;
        logic             ovf;
        logic             divz;
    } pay_t;

    // saturate to 32 bits, msb of the result flags overflow
    function automatic logic [32:0] sat_word(input logic signed [67:0] v);
        logic [32:0] res;
        if (v > 68'sd2147483647)
            res = {1'b1, WORD_MAX};
        else if (v < -68'sd2147483648)
            res = {1'b1, WORD_MIN};
        else
            res = {1'b0, v[31:0]};
        return res;
    endfunction

endpackage

// File: src/vec3_fixed_point_alu_unit.sv
// vec3 fixed-point alu: pipelined vector arithmetic on signed fixed-point components
//
// Takes one item per clock while the output is not held and returns one result item per
// item, in order; components are Q16.16 at the default FRAC_BITS. Every item passes
// through the 32 square-root digit stages and the 32 + FRAC_BITS restoring divider
// stages; four front stages handle the add, the multiplies and the sums. The whole
// pipeline holds while a finished result waits at the output.
module vec3_fixed_point_alu_unit
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         kind,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] r_scalar,
    output logic [1:0]         status
);

    localparam int NW    = 32 + FRAC_BITS;
    localparam int SQ_ST = 32;
    localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: input register
    logic             s1_v_reg;
    logic [3:0]       s1_kind_reg;
    logic [2:0][31:0] s1_a_reg, s1_b_reg;
    logic [31:0]      s1_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= kind;
            s1_a_reg    <= {a_z, a_y, a_x};
            s1_b_reg    <= {b_z, b_y, b_x};
            s1_s_reg    <= scalar;
        end
    end

    // ---------------- stage 2: differences, add, sub, neg
    logic             s2_v_reg;
    logic [3:0]       s2_kind_reg;
    logic [2:0][31:0] s2_a_reg, s2_b_reg;
    logic [31:0]      s2_s_reg;
    logic [2:0][32:0] s2_d_reg, s2_d_next;
    logic             s2_far_reg, s2_far_next;
    logic [2:0][31:0] s2_r_reg, s2_r_next;
    logic             s2_ovf_reg, s2_ovf_next;

    always_comb
    begin
        logic signed [32:0] ae, be, t;
        logic [32:0] sv;
        s2_far_next = 1'b0;
        s2_ovf_next = 1'b0;
        s2_r_next   = '0;
        for (int i = 0; i < 3; i++)
        begin
            ae = {s1_a_reg[i][31], s1_a_reg[i]};
            be = {s1_b_reg[i][31], s1_b_reg[i]};
            s2_d_next[i] = be - ae;
            if ((s2_d_next[i][32] != s2_d_next[i][31]) ||
                (s2_d_next[i] == {2'b11, 31'd0}))
                s2_far_next = 1'b1;
            case (s1_kind_reg)
                KIND_ADD: t = ae + be;
                KIND_SUB: t = ae - be;
                KIND_NEG: t = 33'sd0 - ae;
                default:  t = '0;
            endcase
            sv = sat_word(68'(t));
            s2_r_next[i] = sv[31:0];
            s2_ovf_next  = s2_ovf_next | sv[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_s_reg    <= s1_s_reg;
            s2_d_reg    <= s2_d_next;
            s2_far_reg  <= s2_far_next;
            s2_r_reg    <= s2_r_next;
            s2_ovf_reg  <= s2_ovf_next;
        end
    end

    // ---------------- stage 3: six multipliers
    logic               s3_v_reg;
    logic [3:0]         s3_kind_reg;
    logic [2:0][31:0]   s3_a_reg;
    logic [31:0]        s3_s_reg;
    logic signed [65:0] s3_p_reg [6];
    logic signed [65:0] s3_p_next [6];
    logic               s3_far_reg;
    logic [2:0][31:0]   s3_r_reg;
    logic               s3_ovf_reg;

    always_comb
    begin
        logic signed [32:0] ox [6];
        logic signed [32:0] oy [6];
        logic signed [32:0] ea [3];
        logic signed [32:0] eb [3];
        logic signed [32:0] es;
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = {s2_a_reg[i][31], s2_a_reg[i]};
            eb[i] = {s2_b_reg[i][31], s2_b_reg[i]};
        end
        es = {s2_s_reg[31], s2_s_reg};
        for (int k = 0; k < 6; k++)
        begin
            ox[k] = '0;
            oy[k] = '0;
        end
        case (s2_kind_reg) inside
            KIND_SCALE:
                for (int i = 0; i < 3; i++)
                begin
                    ox[i] = ea[i];
                    oy[i] = es;
                end
            KIND_LERP:
                for (int i = 0; i < 3; i++)
                begin
                    ox[i] = s2_d_reg[i];
                    oy[i] = es;
                end
            KIND_DOT:
                for (int i = 0; i < 3; i++)
                begin
                    ox[i] = ea[i];
                    oy[i] = eb[i];
                end
            KIND_LENSQ, KIND_LEN, KIND_NORM:
                for (int i = 0; i < 3; i++)
                begin
                    ox[i] = ea[i];
                    oy[i] = ea[i];
                end
            KIND_DIST:
                for (int i = 0; i < 3; i++)
                begin
                    ox[i] = s2_d_reg[i];
                    oy[i] = s2_d_reg[i];
                end
            KIND_CROSS:
            begin
                ox[0] = ea[1]; oy[0] = eb[2];
                ox[1] = ea[2]; oy[1] = eb[1];
                ox[2] = ea[2]; oy[2] = eb[0];
                ox[3] = ea[0]; oy[3] = eb[2];
                ox[4] = ea[0]; oy[4] = eb[1];
                ox[5] = ea[1]; oy[5] = eb[0];
            end
            default: ;
        endcase
        for (int k = 0; k < 6; k++)
            s3_p_next[k] = ox[k] * oy[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_a_reg    <= s2_a_reg;
            s3_s_reg    <= s2_s_reg;
            for (int k = 0; k < 6; k++)
                s3_p_reg[k] <= s3_p_next[k];
            s3_far_reg  <= s2_far_reg;
            s3_r_reg    <= s2_r_reg;
            s3_ovf_reg  <= s2_ovf_reg;
        end
    end

    // ---------------- stage 4: sums of products
    logic               s4_v_reg;
    logic [3:0]         s4_kind_reg;
    logic [2:0][31:0]   s4_a_reg;
    logic [31:0]        s4_s_reg;
    logic signed [67:0] s4_sum_reg [3];
    logic signed [67:0] s4_sum_next [3];
    logic               s4_far_reg;
    logic [2:0][31:0]   s4_r_reg;
    logic               s4_ovf_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s4_sum_next[i] = '0;
        case (s3_kind_reg) inside
            KIND_SCALE, KIND_LERP:
                for (int i = 0; i < 3; i++)
                    s4_sum_next[i] = 68'(s3_p_reg[i]);
            KIND_CROSS:
                for (int i = 0; i < 3; i++)
                    s4_sum_next[i] = 68'(s3_p_reg[2*i]) - 68'(s3_p_reg[2*i+1]);
            KIND_DOT, KIND_LENSQ, KIND_LEN, KIND_DIST, KIND_NORM:
                s4_sum_next[0] = 68'(s3_p_reg[0]) + 68'(s3_p_reg[1]) +
                                 68'(s3_p_reg[2]);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (adv)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_a_reg    <= s3_a_reg;
            s4_s_reg    <= s3_s_reg;
            for (int i = 0; i < 3; i++)
                s4_sum_reg[i] <= s4_sum_next[i];
            s4_far_reg  <= s3_far_reg;
            s4_r_reg    <= s3_r_reg;
            s4_ovf_reg  <= s3_ovf_reg;
        end
    end

    // ---------------- rounding, then square-root digit stages
    logic             sq_v_reg   [SQ_ST+1];
    logic [63:0]      sq_x_reg   [SQ_ST+1];
    logic [63:0]      sq_r_reg   [SQ_ST+1];
    pay_t             sq_pay_reg [SQ_ST+1];
    logic [2:0][31:0] sq_a_reg   [SQ_ST+1];
    logic [31:0]      sq_s_reg   [SQ_ST+1];
    pay_t             sq_pay_next;
    logic [63:0]      sq_x_next;

    always_comb
    begin
        logic signed [67:0] rv;
        logic [32:0] sv;
        sq_pay_next.kind = s4_kind_reg;
        sq_pay_next.far  = s4_far_reg;
        sq_pay_next.r    = s4_r_reg;
        sq_pay_next.rs   = '0;
        sq_pay_next.ovf  = s4_ovf_reg;
        sq_pay_next.divz = 1'b0;
        sq_x_next        = '0;
        for (int i = 0; i < 3; i++)
        begin
            rv = (s4_sum_reg[i] + HALF) >>> FRAC_BITS;
            if (s4_kind_reg == KIND_LERP)
                rv = rv + 68'($signed(s4_a_reg[i]));
            sv = sat_word(rv);
            case (s4_kind_reg) inside
                KIND_SCALE, KIND_CROSS, KIND_LERP:
                begin
                    sq_pay_next.r[i] = sv[31:0];
                    sq_pay_next.ovf  = sq_pay_next.ovf | sv[32];
                end
                KIND_DOT, KIND_LENSQ:
                    if (i == 0)
                    begin
                        sq_pay_next.rs  = sv[31:0];
                        sq_pay_next.ovf = sq_pay_next.ovf | sv[32];
                    end
                default: ;
            endcase
        end
        case (s4_kind_reg) inside
            KIND_LEN, KIND_NORM:
                sq_x_next = s4_sum_reg[0][63:0];
            KIND_DIST:
                if (s4_far_reg)
                begin
                    sq_pay_next.rs  = WORD_MAX;
                    sq_pay_next.ovf = 1'b1;
                end
                else
                    sq_x_next = s4_sum_reg[0][63:0];
            KIND_DIV:
                sq_pay_next.divz = (s4_s_reg == 32'd0);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (adv)
            sq_v_reg[0] <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_x_reg[0]   <= sq_x_next;
            sq_r_reg[0]   <= '0;
            sq_pay_reg[0] <= sq_pay_next;
            sq_a_reg[0]   <= s4_a_reg;
            sq_s_reg[0]   <= s4_s_reg;
        end
    end

    for (genvar k = 0; k < SQ_ST; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] t;
        logic [63:0] x_next, r_next;

        always_comb
        begin
            t = sq_r_reg[k] + BIT;
            if (sq_x_reg[k] >= t)
            begin
                x_next = sq_x_reg[k] - t;
                r_next = (sq_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                x_next = sq_x_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (adv)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_x_reg[k+1]   <= x_next;
                sq_r_reg[k+1]   <= r_next;
                sq_pay_reg[k+1] <= sq_pay_reg[k];
                sq_a_reg[k+1]   <= sq_a_reg[k];
                sq_s_reg[k+1]   <= sq_s_reg[k];
            end
        end
    end

    // ---------------- root rounding
    logic             rd_v_reg;
    logic [32:0]      rd_l_reg;
    pay_t             rd_pay_reg;
    logic [2:0][31:0] rd_a_reg;
    logic [31:0]      rd_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_v_reg <= 1'b0;
        else if (adv)
            rd_v_reg <= sq_v_reg[SQ_ST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // remainder above the root means the upper neighbor is nearer
            rd_l_reg   <= sq_r_reg[SQ_ST][32:0] +
                          33'(sq_x_reg[SQ_ST] > sq_r_reg[SQ_ST]);
            rd_pay_reg <= sq_pay_reg[SQ_ST];
            rd_a_reg   <= sq_a_reg[SQ_ST];
            rd_s_reg   <= sq_s_reg[SQ_ST];
        end
    end

    // ---------------- restoring divider stages, three lanes
    logic                   dv_v_reg   [NW+1];
    logic [2:0][NW-1:0]     dv_n_reg   [NW+1];
    logic [2:0][31:0]       dv_rem_reg [NW+1];
    logic [2:0][NW-1:0]     dv_q_reg   [NW+1];
    logic [2:0]             dv_neg_reg [NW+1];
    logic [32:0]            dv_den_reg [NW+1];
    logic                   dv_en_reg  [NW+1];
    pay_t                   dv_pay_reg [NW+1];
    pay_t                   dv_pay_next;
    logic [2:0][NW-1:0]     dv_n_next;
    logic [2:0]             dv_neg_next;
    logic [32:0]            dv_den_next;
    logic                   dv_en_next;

    always_comb
    begin
        logic [32:0] se, sm, ae, am;
        dv_pay_next = rd_pay_reg;
        se = {rd_s_reg[31], rd_s_reg};
        sm = rd_s_reg[31] ? (33'd0 - se) : se;
        if ((rd_pay_reg.kind == KIND_LEN) ||
            (rd_pay_reg.kind == KIND_DIST && !rd_pay_reg.far))
        begin
            if (rd_l_reg > {1'b0, WORD_MAX})
            begin
                dv_pay_next.rs  = WORD_MAX;
                dv_pay_next.ovf = 1'b1;
            end
            else
                dv_pay_next.rs = rd_l_reg[31:0];
        end
        dv_den_next = (rd_pay_reg.kind == KIND_DIV) ? sm : rd_l_reg;
        dv_en_next  = (rd_pay_reg.kind == KIND_DIV && rd_s_reg != 32'd0) ||
                      (rd_pay_reg.kind == KIND_NORM && rd_l_reg != 33'd0);
        for (int j = 0; j < 3; j++)
        begin
            ae = {rd_a_reg[j][31], rd_a_reg[j]};
            am = rd_a_reg[j][31] ? (33'd0 - ae) : ae;
            dv_n_next[j]   = {am[31:0], {FRAC_BITS{1'b0}}};
            dv_neg_next[j] = rd_a_reg[j][31] ^
                             (rd_pay_reg.kind == KIND_DIV && rd_s_reg[31]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= rd_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_n_reg[0]   <= dv_n_next;
            dv_rem_reg[0] <= '0;
            dv_q_reg[0]   <= '0;
            dv_neg_reg[0] <= dv_neg_next;
            dv_den_reg[0] <= dv_den_next;
            dv_en_reg[0]  <= dv_en_next;
            dv_pay_reg[0] <= dv_pay_next;
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        logic [2:0][31:0]   rem_next;
        logic [2:0][NW-1:0] q_next;
        logic [2:0][NW-1:0] n_next;

        always_comb
        begin
            logic [32:0] sh;
            for (int j = 0; j < 3; j++)
            begin
                sh = {dv_rem_reg[k][j], dv_n_reg[k][j][NW-1]};
                if (sh >= dv_den_reg[k])
                begin
                    rem_next[j] = 32'(sh - dv_den_reg[k]);
                    q_next[j]   = {dv_q_reg[k][j][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = sh[31:0];
                    q_next[j]   = {dv_q_reg[k][j][NW-2:0], 1'b0};
                end
                n_next[j] = dv_n_reg[k][j] << 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (adv)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_n_reg[k+1]   <= n_next;
                dv_rem_reg[k+1] <= rem_next;
                dv_q_reg[k+1]   <= q_next;
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_den_reg[k+1] <= dv_den_reg[k];
                dv_en_reg[k+1]  <= dv_en_reg[k];
                dv_pay_reg[k+1] <= dv_pay_reg[k];
            end
        end
    end

    // ---------------- quotient rounding and output register
    logic [2:0][31:0] out_r_reg, out_r_next;
    logic [31:0]      out_rs_reg;
    logic [1:0]       out_st_reg, out_st_next;

    always_comb
    begin
        pay_t p;
        logic ovf;
        logic [NW:0] qq;
        p   = dv_pay_reg[NW];
        ovf = p.ovf;
        out_r_next = p.r;
        for (int j = 0; j < 3; j++)
        begin
            // ties away from zero: round up when twice the remainder reaches the divisor
            qq = {1'b0, dv_q_reg[NW][j]} +
                 (NW+1)'({dv_rem_reg[NW][j], 1'b0} >= dv_den_reg[NW]);
            if (dv_en_reg[NW])
            begin
                if (dv_neg_reg[NW][j])
                begin
                    if (qq > (NW+1)'(33'h0_8000_0000))
                    begin
                        out_r_next[j] = WORD_MIN;
                        ovf = 1'b1;
                    end
                    else
                        out_r_next[j] = 32'((NW+1)'(0) - qq);
                end
                else
                begin
                    if (qq > (NW+1)'(WORD_MAX))
                    begin
                        out_r_next[j] = WORD_MAX;
                        ovf = 1'b1;
                    end
                    else
                        out_r_next[j] = qq[31:0];
                end
            end
        end
        if (p.divz)
            out_st_next = ST_DIVZ;
        else if (ovf)
            out_st_next = ST_OVF;
        else
            out_st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_v_reg[NW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_r_reg  <= out_r_next;
            out_rs_reg <= dv_pay_reg[NW].rs;
            out_st_reg <= out_st_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_x       = out_r_reg[0];
    assign r_y       = out_r_reg[1];
    assign r_z       = out_r_reg[2];
    assign r_scalar  = out_rs_reg;
    assign status    = out_st_reg;

endmodule
